// File: rtl/hcrd_pkg.sv
// ----------------------------------------------------------------------------
// HTML character reference decoder package
// Shared word types, parse-mode codes and the named reference table.
// ----------------------------------------------------------------------------
package hcrd_pkg;

  localparam int PendingMax = 32;
  localparam int PendAw = $clog2(PendingMax);
  localparam int PendCw = $clog2(PendingMax + 1);
  localparam int NameMax = 6;
  localparam int NumRefs = 24;

  localparam logic [2:0] MODE_PLAIN    = 3'd0;
  localparam logic [2:0] MODE_AMP      = 3'd1;
  localparam logic [2:0] MODE_HASH     = 3'd2;
  localparam logic [2:0] MODE_HEXSTART = 3'd3;
  localparam logic [2:0] MODE_DIGITS   = 3'd4;
  localparam logic [2:0] MODE_NAME     = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } out_word_t;

  // Names packed first character in the low byte, zero padded.
  typedef struct packed {
    logic [47:0] name;
    logic [2:0]  len;
    logic [20:0] cp;
  } name_ref_t;

  function automatic name_ref_t ref_entry(input logic [4:0] k);
    name_ref_t r;
    r = '0;
    case (k)
      5'd0:  r = '{48'h706d61, 3'd3, 21'h26};
      5'd1:  r = '{48'h746c, 3'd2, 21'h3C};
      5'd2:  r = '{48'h7467, 3'd2, 21'h3E};
      5'd3:  r = '{48'h746f7571, 3'd4, 21'h22};
      5'd4:  r = '{48'h736f7061, 3'd4, 21'h27};
      5'd5:  r = '{48'h7073626e, 3'd4, 21'hA0};
      5'd6:  r = '{48'h79706f63, 3'd4, 21'hA9};
      5'd7:  r = '{48'h676572, 3'd3, 21'hAE};
      5'd8:  r = '{48'h6564617274, 3'd5, 21'h2122};
      5'd9:  r = '{48'h687361646d, 3'd5, 21'h2014};
      5'd10: r = '{48'h687361646e, 3'd5, 21'h2013};
      5'd11: r = '{48'h70696c6c6568, 3'd6, 21'h2026};
      5'd12: r = '{48'h6f7571736c, 3'd5, 21'h2018} ;
      5'd13: r = '{48'h6f75717372, 3'd5, 21'h2019};
      5'd14: r = '{48'h6f7571646c, 3'd5, 21'h201C};
      5'd15: r = '{48'h6f75716472, 3'd5, 21'h201D};
      5'd16: r = '{48'h6f727565, 3'd4, 21'h20AC};
      5'd17: r = '{48'h646e756f70, 3'd5, 21'hA3};
      5'd18: r = '{48'h6e6579, 3'd3, 21'hA5};
      5'd19: r = '{48'h746e6563, 3'd4, 21'hA2};
      5'd20: r = '{48'h74636573, 3'd4, 21'hA7};
      5'd21: r = '{48'h61726170, 3'd4, 21'hB6};
      5'd22: r = '{48'h746f6464696d, 3'd6, 21'hB7};
      5'd23: r = '{48'h676564, 3'd3, 21'hB0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/hcrd_pend_ram.sv
// ----------------------------------------------------------------------------
// Pending byte store
// One write port and one registered read port holding bytes after '&'.
// ----------------------------------------------------------------------------
module hcrd_pend_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [hcrd_pkg::PendAw-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic [hcrd_pkg::PendAw-1:0] raddr,
  output logic [7:0]                  rdata
);

  logic [7:0] mem [hcrd_pkg::PendingMax];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/html_char_reference_decoder.sv
// ----------------------------------------------------------------------------
// HTML character reference decoder
// Replaces &name; and numeric references in a byte stream by UTF-8 bytes.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  in      | input     | in_word_t   | in_valid / in_ready
//  out     | output    | out_word_t  | out_valid / out_ready
//
// A plain byte is emitted as one word. A reference byte that is held emits
// nothing. After a closing ';' the one to four UTF-8 words of the replacement
// follow, one per cycle while the output is taken. A failed reference emits '&',
// then each held byte (a memory read, then the word), then clears the reference
// and handles the failing byte.
// Reset is synchronous and returns to plain text.
// The output word register stalls all work while it is full and not taken.
module html_char_reference_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcrd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output hcrd_pkg::out_word_t out_word
);

  localparam int Aw = hcrd_pkg::PendAw;
  localparam int Cw = hcrd_pkg::PendCw;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;  // accept next byte
  localparam logic [2:0] ST_CP    = 3'd1;  // emitting code point bytes
  localparam logic [2:0] ST_AMP   = 3'd2;  // replay: emit '&'
  localparam logic [2:0] ST_REPL  = 3'd3;  // replay: emit held bytes
  localparam logic [2:0] ST_AFTER = 3'd4;  // replay done: redo the byte

  logic [2:0]    state;
  logic [2:0]    mode;
  logic [Cw-1:0] count;
  logic [24:0]   number;
  logic          ovf;
  logic          hex;
  logic [47:0]   name;          // shadow of the first name letters
  logic [7:0]    cur;           // byte being worked on
  logic          cur_end;
  logic          redo;          // after replay, redo cur as plain
  logic          flush;         // replay is the end-of-text flush
  logic [31:0]   cpbytes;
  logic [2:0]    cpn;
  logic [2:0]    cpi;
  logic [Cw-1:0] ridx;
  logic          rvalid;

  logic          ow_full;
  logic          ow_room;
  assign ow_room = !ow_full || out_ready;
  assign out_valid = ow_full;

  // Memory access.
  logic          we;
  logic [Aw-1:0] raddr;
  logic [7:0]    rdata;
  hcrd_pend_ram u_ram (
    .clk(clk), .we(we), .waddr(count[Aw-1:0]), .wdata(in_word.in_byte),
    .raddr(raddr), .rdata(rdata)
  );

  // Byte classes for the incoming byte.
  logic [7:0] c;
  logic is_let, is_dec, is_hexd, full;
  logic [3:0] dval;
  assign c = in_word.in_byte;
  assign is_let = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_dec = c >= 8'h30 && c <= 8'h39;
  assign is_hexd = is_dec || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  assign full = count >= Cw'(hcrd_pkg::PendingMax);
  always_comb begin
    if (is_dec) dval = 4'(c - 8'h30);
    else if (c >= 8'h61) dval = 4'(c - 8'h57);
    else dval = 4'(c - 8'h37);
  end

  logic [24:0] acc_next;
  logic        acc_ovf;
  always_comb begin
    acc_ovf = number > 25'h10FFFF;
    acc_next = hex ? {number[20:0], 4'b0} + 25'(dval)
                   : 25'({number, 3'b0} + {number, 1'b0}) + 25'(dval);
  end

  // Name lookup over the shadow register.
  logic        hit;
  logic [20:0] hit_cp;
  always_comb begin
    hcrd_pkg::name_ref_t e;
    hit = 1'b0;
    hit_cp = '0;
    for (int k = 0; k < hcrd_pkg::NumRefs; k++) begin
      e = hcrd_pkg::ref_entry(5'(k));
      if (Cw'(e.len) == count && e.name == name && !hit) begin
        hit = 1'b1;
        hit_cp = e.cp;
      end
    end
  end

  // Code point to UTF-8 bytes, first byte in the low lane.
  function automatic logic [34:0] utf8(input logic [20:0] cp);
    logic [7:0] b0, b1, b2, b3;
    b3 = {2'b10, cp[5:0]};
    b2 = {2'b10, cp[11:6]};
    b1 = {2'b10, cp[17:12]};
    if (cp < 21'h80) return {3'd1, 24'h0, cp[7:0]};
    if (cp < 21'h800) return {3'd2, 16'h0, b3, 3'b110, cp[10:6]};
    if (cp < 21'h10000) return {3'd3, 8'h0, b3, b2, 4'b1110, cp[15:12]};
    b0 = {5'b11110, cp[20:18]};
    return {3'd4, b3, b2, b1, b0};
  endfunction

  logic [20:0] num_cp;
  always_comb begin
    if (ovf || number > 25'h10FFFF || number == 0 ||
        (number >= 25'hD800 && number <= 25'hDFFF)) num_cp = 21'hFFFD;
    else num_cp = number[20:0];
  end

  // Whether the byte is held in the current mode.
  logic hold_ok;
  always_comb begin
    unique case (mode)
      hcrd_pkg::MODE_AMP:      hold_ok = c == 8'h23 || is_let;
      hcrd_pkg::MODE_HASH:     hold_ok = c == 8'h78 || c == 8'h58 || is_dec;
      hcrd_pkg::MODE_HEXSTART: hold_ok = is_hexd;
      hcrd_pkg::MODE_DIGITS:   hold_ok = hex ? is_hexd : is_dec;
      hcrd_pkg::MODE_NAME:     hold_ok = is_let;
      default:                 hold_ok = 1'b0;
    endcase
  end

  assign in_ready = state == ST_IDLE && ow_room && !redo;
  logic acc;
  assign acc = in_valid && in_ready;
  assign we = acc && hold_ok && !full;

  // The replay's final word ends the byte's run unless the failing byte still
  // emits a word of its own afterwards.
  logic rep_last;
  assign rep_last = flush || (cur == 8'h26 && !cur_end);

  // A new output word is loaded in this cycle.
  logic load;
  always_comb begin
    load = 1'b0;
    if (ow_room) begin
      unique case (state)
        ST_IDLE: begin
          if (redo) load = !(cur == 8'h26 && !cur_end);
          else load = acc && mode == hcrd_pkg::MODE_PLAIN &&
                      !(c == 8'h26 && !in_word.text_end);
        end
        ST_CP, ST_AMP: load = 1'b1;
        ST_REPL: load = rvalid;
        default: load = 1'b0;
      endcase
    end
  end

  assign raddr = ridx[Aw-1:0];

  task automatic push(input logic [7:0] b, input logic last, input logic done);
    out_word <= '{b, last, done};
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      ow_full <= 1'b0;
    end else if (load) begin
      ow_full <= 1'b1;
    end else if (out_ready) begin
      ow_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode <= hcrd_pkg::MODE_PLAIN;
      count <= '0;
      number <= '0;
      ovf <= 1'b0;
      hex <= 1'b0;
      redo <= 1'b0;
      flush <= 1'b0;
      rvalid <= 1'b0;
      name <= '0;
    end else begin
      if (ow_room) begin
        unique case (state)
          ST_IDLE: begin
            if (redo) begin
              // Failing byte handled as plain text; a '&' not at the end opens a new reference.
              redo <= 1'b0;
              if (cur == 8'h26) begin
                if (cur_end) push(8'h26, 1'b1, 1'b1);
                else mode <= hcrd_pkg::MODE_AMP;
              end else begin
                push(cur, 1'b1, cur_end);
              end
            end else if (acc) begin
              cur <= c;
              cur_end <= in_word.text_end;
              if (mode == hcrd_pkg::MODE_PLAIN) begin
                if (c == 8'h26) begin
                  if (in_word.text_end) push(8'h26, 1'b1, 1'b1);
                  else begin
                    mode <= hcrd_pkg::MODE_AMP;
                    count <= '0; number <= '0; ovf <= 1'b0; hex <= 1'b0; name <= '0;
                  end
                end else push(c, 1'b1, in_word.text_end);
              end else if (hold_ok && !full) begin
                count <= count + 1'b1;
                if (count < Cw'(hcrd_pkg::NameMax))
                  name[8*count[2:0] +: 8] <= c;
                unique case (mode)
                  hcrd_pkg::MODE_AMP:
                    mode <= (c == 8'h23) ? hcrd_pkg::MODE_HASH : hcrd_pkg::MODE_NAME;
                  hcrd_pkg::MODE_HASH: begin
                    if (c == 8'h78 || c == 8'h58) begin
                      hex <= 1'b1;
                      mode <= hcrd_pkg::MODE_HEXSTART;
                    end else begin
                      number <= acc_next;
                      mode <= hcrd_pkg::MODE_DIGITS;
                    end
                  end
                  hcrd_pkg::MODE_HEXSTART, hcrd_pkg::MODE_DIGITS: begin
                    if (acc_ovf) ovf <= 1'b1;
                    else number <= acc_next;
                    mode <= hcrd_pkg::MODE_DIGITS;
                  end
                  default: ;
                endcase
                if (in_word.text_end) begin
                  // Held byte is the last: flush '&' and all held bytes.
                  state <= ST_AMP;
                  flush <= 1'b1;
                end
              end else if (c == 8'h3B && mode == hcrd_pkg::MODE_DIGITS) begin
                {cpn, cpbytes} <= utf8(num_cp);
                cpi <= 3'd0;
                state <= ST_CP;
              end else if (c == 8'h3B && mode == hcrd_pkg::MODE_NAME && hit) begin
                {cpn, cpbytes} <= utf8(hit_cp);
                cpi <= 3'd0;
                state <= ST_CP;
              end else begin
                state <= ST_AMP;
                flush <= 1'b0;
              end
            end
          end
          ST_CP: begin
            push(cpbytes[8*cpi[1:0] +: 8], cpi + 1'b1 == cpn, cur_end && cpi + 1'b1 == cpn);
            cpi <= cpi + 1'b1;
            if (cpi + 1'b1 == cpn) begin
              state <= ST_IDLE;
              mode <= hcrd_pkg::MODE_PLAIN;
            end
          end
          ST_AMP: begin
            push(8'h26, count == 0 && rep_last, count == 0 && flush);
            ridx <= '0;
            rvalid <= 1'b0;
            state <= (count == 0) ? ST_AFTER : ST_REPL;
          end
          ST_REPL: begin
            if (!rvalid) begin
              rvalid <= 1'b1;
            end else begin
              push(rdata, ridx + 1'b1 == count && rep_last,
                   ridx + 1'b1 == count && flush);
              ridx <= ridx + 1'b1;
              rvalid <= 1'b0;
              if (ridx + 1'b1 == count) state <= ST_AFTER;
            end
          end
          default: begin
            state <= ST_IDLE;
            mode <= hcrd_pkg::MODE_PLAIN;
            count <= '0; number <= '0; ovf <= 1'b0; hex <= 1'b0; name <= '0;
            redo <= !flush;
          end
        endcase
      end
    end
  end

  no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready) else $error("byte taken while busy");
  count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Cw'(hcrd_pkg::PendingMax)) else $error("pending count overrun");
  out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("output word dropped or changed while stalled");

endmodule
